[hw/rtl/twims_pkg.sv]
// ----------------------------------------------------------------------------
// twims_pkg
// Shared types and codes for the two-wire master-transmit / slave-receive
// sequencer: transaction payloads, commands, bus status codes and actions.
// ----------------------------------------------------------------------------
`default_nettype none

package twims_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int IDX_W     = $clog2(BUF_DEPTH);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);

    // host commands
    localparam logic [1:0] CMD_STATUS   = 2'd0;
    localparam logic [1:0] CMD_PUSH     = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;
    localparam logic [1:0] CMD_RX_CLEAR = 2'd3;

    // bus status codes (status byte >> 3)
    localparam logic [4:0] SC_START      = 5'd1;
    localparam logic [4:0] SC_RSTART     = 5'd2;
    localparam logic [4:0] SC_ADDR_ACK   = 5'd3;
    localparam logic [4:0] SC_ADDR_NACK  = 5'd4;
    localparam logic [4:0] SC_DATA_ACK   = 5'd5;
    localparam logic [4:0] SC_DATA_NACK  = 5'd6;
    localparam logic [4:0] SC_ARB_LOST   = 5'd7;
    localparam logic [4:0] SC_OWN_ADDR   = 5'd12;
    localparam logic [4:0] SC_GEN_CALL   = 5'd14;
    localparam logic [4:0] SC_RX_ACKED   = 5'd16;
    localparam logic [4:0] SC_RX_NACKED  = 5'd17;
    localparam logic [4:0] SC_SLAVE_STOP = 5'd20;

    // actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_ACK      = 3'd1;
    localparam logic [2:0] ACT_NACK     = 3'd2;
    localparam logic [2:0] ACT_START    = 3'd3;
    localparam logic [2:0] ACT_STOP     = 3'd4;
    localparam logic [2:0] ACT_STOP_ACK = 3'd5;

    // bus state as reported
    localparam logic [1:0] BS_IDLE  = 2'd0;
    localparam logic [1:0] BS_BUSY  = 2'd1;
    localparam logic [1:0] BS_ERROR = 2'd2;

    // configuration register indexes
    localparam logic REG_PEER_ADDR   = 1'b0;
    localparam logic REG_RETRY_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] status_code;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic       drive_valid;
        logic [7:0] drive_byte;
        logic [1:0] bus_state;
        logic       rx_valid;
        logic [4:0] rx_index;
        logic [7:0] rx_data;
        logic       frame_done;
        logic [5:0] frame_length;
    } t_out_item;

endpackage

`default_nettype wire

[hw/rtl/twims_fsm.sv]
// ----------------------------------------------------------------------------
// twims_fsm
// Sequencer state, transmit buffer and the per-transaction decision logic.
// Result is combinational from the registered transaction; state advances
// when i_step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module twims_fsm (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_step,
    input  wire twims_pkg::t_in_item   i_item,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire [7:0]                  i_cfg_data,
    output twims_pkg::t_out_item       o_result
);

    typedef enum logic [1:0] {
        LINK_IDLE  = 2'd0,
        LINK_BUSY  = 2'd1,
        LINK_ERROR = 2'd2
    } t_link;

    logic [7:0]                  r_peer_addr;
    logic [7:0]                  r_retry_limit;
    logic [7:0]                  r_tx_store [twims_pkg::BUF_DEPTH];
    logic [7:0]                  r_tx_rd;
    logic [twims_pkg::CNT_W-1:0] r_tx_fill, n_tx_fill;
    logic [twims_pkg::CNT_W-1:0] r_tx_next, n_tx_next;
    logic [twims_pkg::CNT_W-1:0] r_tx_left, n_tx_left;
    logic [7:0]                  r_retry_count, n_retry_count;
    t_link                       r_link, n_link;
    logic [twims_pkg::CNT_W-1:0] r_rx_count, n_rx_count;

    logic                        store_we;
    twims_pkg::t_out_item        res;

    always_comb begin
        n_tx_fill     = r_tx_fill;
        n_tx_next     = r_tx_next;
        n_tx_left     = r_tx_left;
        n_retry_count = r_retry_count;
        n_link        = r_link;
        n_rx_count    = r_rx_count;
        store_we      = 1'b0;
        res           = '0;

        case (i_item.cmd)
            twims_pkg::CMD_STATUS: begin
                case (i_item.status_code)
                    twims_pkg::SC_START, twims_pkg::SC_RSTART: begin
                        res.drive_valid = 1'b1;
                        res.drive_byte  = r_peer_addr;
                        res.action      = twims_pkg::ACT_ACK;
                    end
                    twims_pkg::SC_ADDR_ACK, twims_pkg::SC_DATA_ACK,
                    twims_pkg::SC_DATA_NACK: begin
                        if (r_tx_left != '0 && r_tx_next < twims_pkg::DEPTH_CNT) begin
                            res.drive_valid = 1'b1;
                            res.drive_byte  = r_tx_rd;
                            res.action      = twims_pkg::ACT_ACK;
                            n_tx_next       = r_tx_next + 1'b1;
                            n_tx_left       = r_tx_left - 1'b1;
                        end else begin
                            // nothing left, including a zero-length send
                            n_tx_left  = '0;
                            n_link     = LINK_IDLE;
                            res.action = twims_pkg::ACT_STOP;
                        end
                    end
                    twims_pkg::SC_ADDR_NACK: begin
                        if (r_retry_count > r_retry_limit) begin
                            n_link     = LINK_ERROR;
                            res.action = twims_pkg::ACT_STOP;
                        end else begin
                            res.action = twims_pkg::ACT_START;
                        end
                        if (r_retry_count != 8'hff) begin
                            n_retry_count = r_retry_count + 8'd1;
                        end
                    end
                    twims_pkg::SC_ARB_LOST: begin
                        res.action = twims_pkg::ACT_START;
                    end
                    twims_pkg::SC_OWN_ADDR, twims_pkg::SC_GEN_CALL: begin
                        n_link     = LINK_BUSY;
                        res.action = twims_pkg::ACT_ACK;
                    end
                    twims_pkg::SC_RX_ACKED: begin
                        if (r_rx_count < twims_pkg::DEPTH_CNT) begin
                            res.rx_valid = 1'b1;
                            res.rx_index = r_rx_count[4:0];
                            res.rx_data  = i_item.rx_byte;
                            n_rx_count   = r_rx_count + 1'b1;
                            // nack the byte that fills the buffer
                            res.action   = (n_rx_count == twims_pkg::DEPTH_CNT) ?
                                           twims_pkg::ACT_NACK : twims_pkg::ACT_ACK;
                        end else begin
                            res.action = twims_pkg::ACT_NACK;
                        end
                    end
                    twims_pkg::SC_RX_NACKED: begin
                        res.action       = twims_pkg::ACT_STOP_ACK;
                        res.frame_done   = 1'b1;
                        res.frame_length = 6'(r_rx_count);
                    end
                    twims_pkg::SC_SLAVE_STOP: begin
                        n_link           = LINK_IDLE;
                        res.action       = twims_pkg::ACT_NACK;
                        res.frame_done   = 1'b1;
                        res.frame_length = 6'(r_rx_count);
                    end
                    default: begin
                        res.action = twims_pkg::ACT_ACK;
                    end
                endcase
            end
            twims_pkg::CMD_PUSH: begin
                if (r_tx_fill < twims_pkg::DEPTH_CNT) begin
                    store_we  = 1'b1;
                    n_tx_fill = r_tx_fill + 1'b1;
                end
                res.action = twims_pkg::ACT_NONE;
            end
            twims_pkg::CMD_START: begin
                if (r_link != LINK_BUSY) begin
                    n_tx_left     = r_tx_fill;
                    n_tx_next     = '0;
                    n_tx_fill     = '0;
                    n_retry_count = '0;
                    n_link        = LINK_BUSY;
                    res.action    = twims_pkg::ACT_START;
                end
            end
            default: begin
                n_rx_count = '0;
                res.action = twims_pkg::ACT_ACK;
            end
        endcase

        res.bus_state = n_link;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_addr   <= 8'd0;
            r_retry_limit <= 8'd5;
            r_tx_fill     <= '0;
            r_tx_next     <= '0;
            r_tx_left     <= '0;
            r_retry_count <= '0;
            r_link        <= LINK_IDLE;
            r_rx_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    twims_pkg::REG_PEER_ADDR:   r_peer_addr   <= i_cfg_data;
                    twims_pkg::REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_step) begin
                r_tx_fill     <= n_tx_fill;
                r_tx_next     <= n_tx_next;
                r_tx_left     <= n_tx_left;
                r_retry_count <= n_retry_count;
                r_link        <= n_link;
                r_rx_count    <= n_rx_count;
            end
        end
    end

    // transmit buffer, no reset
    // the byte at the next send position is fetched ahead, a push to that slot is forwarded
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_tx_store[r_tx_fill[twims_pkg::IDX_W-1:0]] <= i_item.tx_byte;
        end
        if (i_step) begin
            if (store_we &&
                r_tx_fill[twims_pkg::IDX_W-1:0] == n_tx_next[twims_pkg::IDX_W-1:0]) begin
                r_tx_rd <= i_item.tx_byte;
            end else begin
                r_tx_rd <= r_tx_store[n_tx_next[twims_pkg::IDX_W-1:0]];
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/twi_master_tx_slave_rx_sequencer.sv]
// an input is taken into the input register, its result into the result register
// one transaction per cycle unless the output stalls; each is a single decision
// in twims_fsm between the input register and the result register
// a stalled output holds the result and back-pressures through one input register
// reset (synchronous, active low) clears both valid flags, all counters, the bus
// state and the configuration registers to their defaults; the transmit buffer is not cleared
// ----------------------------------------------------------------------------
// twi_master_tx_slave_rx_sequencer
// Two-wire bus sequencer for master transmit and slave receive, driven by
// bus status events and host commands, one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module twi_master_tx_slave_rx_sequencer (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire twims_pkg::t_in_item   i_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output twims_pkg::t_out_item       o_out,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire [7:0]                  i_cfg_data
);

    logic                 r_in_vld;
    twims_pkg::t_in_item  r_in;
    logic                 r_out_vld;
    twims_pkg::t_out_item r_out;
    logic                 step;
    twims_pkg::t_out_item result;

    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    twims_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[hw/rtl/twims_checker.sv]
// ----------------------------------------------------------------------------
// twims_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twims_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       o_out_valid,
    input wire                       i_out_ready,
    input wire twims_pkg::t_out_item o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a byte to drive always comes with an ack
    a_drive_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.drive_valid |-> o_out.action == twims_pkg::ACT_ACK)
        else $error("drive byte without ack");

    // a stored byte and a frame end never share a transaction
    a_rx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.rx_valid && o_out.frame_done))
        else $error("rx byte and frame end together");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_done |->
            o_out.frame_length <= 6'(twims_pkg::BUF_DEPTH))
        else $error("frame length beyond buffer depth");

endmodule

bind twi_master_tx_slave_rx_sequencer twims_checker u_twims_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire

[sim/twims_action_checker.sv]
// ----------------------------------------------------------------------------
// twims_action_checker
// Watches the input and result channels of the two-wire sequencer. It keeps
// its own copy of the transmit buffer, counters, bus state and registers,
// predicts the result of every accepted input transaction and compares each
// delivered result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module twims_action_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  twims_pkg::t_in_item  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  twims_pkg::t_out_item i_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] peer_addr;
    logic [7:0] retry_limit;
    logic [7:0] tx_store [twims_pkg::BUF_DEPTH];
    int         tx_fill;
    int         tx_next;
    int         tx_left;
    int         retry_count;
    int         rx_count;
    logic [1:0] link_state;

    twims_pkg::t_out_item expected_actions [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic void clear_bus_model();
        peer_addr   = 8'h00;
        retry_limit = 8'd5;
        for (int i = 0; i < twims_pkg::BUF_DEPTH; i++) begin
            tx_store[i] = 8'h00;
        end
        tx_fill     = 0;
        tx_next     = 0;
        tx_left     = 0;
        retry_count = 0;
        rx_count    = 0;
        link_state  = twims_pkg::BS_IDLE;
    endfunction

    // next queued byte with ack, or stop once the send is used up
    function automatic void send_next_byte(ref twims_pkg::t_out_item r);
        if (tx_left != 0 && tx_next < twims_pkg::BUF_DEPTH) begin
            r.drive_valid = 1'b1;
            r.drive_byte  = tx_store[tx_next];
            tx_next++;
            tx_left--;
            r.action = twims_pkg::ACT_ACK;
        end else begin
            tx_left    = 0;
            link_state = twims_pkg::BS_IDLE;
            r.action   = twims_pkg::ACT_STOP;
        end
    endfunction

    function automatic twims_pkg::t_out_item next_bus_action(twims_pkg::t_in_item it);
        twims_pkg::t_out_item r;
        r = '0;
        case (it.cmd)
            twims_pkg::CMD_STATUS: begin
                case (it.status_code)
                    twims_pkg::SC_START, twims_pkg::SC_RSTART: begin
                        r.drive_valid = 1'b1;
                        r.drive_byte  = peer_addr;
                        r.action      = twims_pkg::ACT_ACK;
                    end
                    twims_pkg::SC_ADDR_ACK, twims_pkg::SC_DATA_ACK,
                    twims_pkg::SC_DATA_NACK: begin
                        send_next_byte(r);
                    end
                    twims_pkg::SC_ADDR_NACK: begin
                        if (retry_count > retry_limit) begin
                            link_state = twims_pkg::BS_ERROR;
                            r.action   = twims_pkg::ACT_STOP;
                        end else begin
                            r.action = twims_pkg::ACT_START;
                        end
                        if (retry_count < 255) retry_count++;
                    end
                    twims_pkg::SC_ARB_LOST: begin
                        r.action = twims_pkg::ACT_START;
                    end
                    twims_pkg::SC_OWN_ADDR, twims_pkg::SC_GEN_CALL: begin
                        link_state = twims_pkg::BS_BUSY;
                        r.action   = twims_pkg::ACT_ACK;
                    end
                    twims_pkg::SC_RX_ACKED: begin
                        if (rx_count < twims_pkg::BUF_DEPTH) begin
                            r.rx_valid = 1'b1;
                            r.rx_index = 5'(rx_count);
                            r.rx_data  = it.rx_byte;
                            rx_count++;
                            r.action = (rx_count == twims_pkg::BUF_DEPTH) ?
                                       twims_pkg::ACT_NACK : twims_pkg::ACT_ACK;
                        end else begin
                            r.action = twims_pkg::ACT_NACK;
                        end
                    end
                    twims_pkg::SC_RX_NACKED: begin
                        r.action       = twims_pkg::ACT_STOP_ACK;
                        r.frame_done   = 1'b1;
                        r.frame_length = 6'(rx_count);
                    end
                    twims_pkg::SC_SLAVE_STOP: begin
                        link_state     = twims_pkg::BS_IDLE;
                        r.action       = twims_pkg::ACT_NACK;
                        r.frame_done   = 1'b1;
                        r.frame_length = 6'(rx_count);
                    end
                    default: begin
                        r.action = twims_pkg::ACT_ACK;
                    end
                endcase
            end
            twims_pkg::CMD_PUSH: begin
                // a full buffer drops the byte
                if (tx_fill < twims_pkg::BUF_DEPTH) begin
                    tx_store[tx_fill] = it.tx_byte;
                    tx_fill++;
                end
                r.action = twims_pkg::ACT_NONE;
            end
            twims_pkg::CMD_START: begin
                if (link_state != twims_pkg::BS_BUSY) begin
                    tx_left     = tx_fill;
                    tx_next     = 0;
                    tx_fill     = 0;
                    retry_count = 0;
                    link_state  = twims_pkg::BS_BUSY;
                    r.action    = twims_pkg::ACT_START;
                end
            end
            default: begin
                rx_count = 0;
                r.action = twims_pkg::ACT_ACK;
            end
        endcase
        r.bus_state = link_state;
        return r;
    endfunction

    function automatic string show(twims_pkg::t_out_item r);
        return $sformatf("act=%0d drv=%0d/%02h bus=%0d rx=%0d/%0d/%02h done=%0d/%0d",
                         r.action, r.drive_valid, r.drive_byte, r.bus_state, r.rx_valid,
                         r.rx_index, r.rx_data, r.frame_done, r.frame_length);
    endfunction

    function automatic string wrong_fields(twims_pkg::t_out_item e, twims_pkg::t_out_item a);
        string s;
        s = "";
        if (a.action !== e.action)             s = {s, " action"};
        if (a.drive_valid !== e.drive_valid)   s = {s, " drive_valid"};
        if (a.drive_byte !== e.drive_byte)     s = {s, " drive_byte"};
        if (a.bus_state !== e.bus_state)       s = {s, " bus_state"};
        if (a.rx_valid !== e.rx_valid)         s = {s, " rx_valid"};
        if (a.rx_index !== e.rx_index)         s = {s, " rx_index"};
        if (a.rx_data !== e.rx_data)           s = {s, " rx_data"};
        if (a.frame_done !== e.frame_done)     s = {s, " frame_done"};
        if (a.frame_length !== e.frame_length) s = {s, " frame_length"};
        return s;
    endfunction

    function automatic void note_mismatch(string what);
        o_mismatches++;
        if (o_mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    always @(posedge i_clk) begin : monitor
        twims_pkg::t_out_item want;
        string                bad;
        if (!i_rst_n) begin
            clear_bus_model();
            expected_actions.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == twims_pkg::REG_PEER_ADDR) peer_addr = i_cfg_data;
                else                                       retry_limit = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_actions.size() == 0) begin
                    note_mismatch({"result with nothing expected: ", show(i_out)});
                end else begin
                    want = expected_actions.pop_front();
                    o_checked++;
                    bad = wrong_fields(want, i_out);
                    if (bad != "") begin
                        note_mismatch({"wrong", bad, "; expected ", show(want),
                                       ", got ", show(i_out)});
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_actions.push_back(next_bus_action(i_in));
            end
        end
        o_pending = expected_actions.size();
    end

endmodule

[sim/twi_master_tx_slave_rx_sequencer_test.sv]
// ----------------------------------------------------------------------------
// twi_master_tx_slave_rx_sequencer_test
// Drives the sequencer with directed and random host commands and bus status
// sequences (master sends with address retries, slave frames up to overflow)
// under random stalls on both channels and several register settings. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module twi_master_tx_slave_rx_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_SETTING = 280;
    localparam int SETTINGS_RUN      = 5;
    localparam int PRESSURE_AFTER    = 300;
    localparam int PRESSURE_CYCLES   = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_ready;
    twims_pkg::t_in_item  in_item;
    logic                 out_valid;
    logic                 out_ready;
    twims_pkg::t_out_item out_item;
    logic                 cfg_we;
    logic                 cfg_idx;
    logic [7:0]           cfg_data;

    int mismatches;
    int pending;
    int checked;
    int sent;
    int counted;
    bit calm;
    bit pressure_done;
    int hold_left;

    twi_master_tx_slave_rx_sequencer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    twims_action_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d results still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 11) == 0) return $urandom_range(12, 48);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls plus one long hold-off to fill the block
    initial begin : result_sink
        out_ready <= 1'b0;
        hold_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!pressure_done && checked >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                hold_left = gap_len() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // one input transaction; returns at the edge that accepted it
    task automatic offer(logic [1:0] cmd, logic [4:0] code, logic [7:0] rxb,
                         logic [7:0] txb);
        twims_pkg::t_in_item it;
        int                  n;
        it.cmd         = cmd;
        it.status_code = code;
        it.rx_byte     = rxb;
        it.tx_byte     = txb;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = gap_len();
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(negedge i_clk); while (!in_ready);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic status(logic [4:0] code);
        offer(twims_pkg::CMD_STATUS, code, 8'($urandom), 8'($urandom));
    endtask

    task automatic host(logic [1:0] cmd);
        offer(cmd, 5'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic noise(int n);
        repeat (n) offer(2'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic directed();
        int first;
        first = sent;
        host(twims_pkg::CMD_RX_CLEAR);
        // send with nothing queued ends in a stop after the address ack
        host(twims_pkg::CMD_START);
        status(twims_pkg::SC_START);
        status(twims_pkg::SC_ADDR_ACK);
        offer(twims_pkg::CMD_PUSH, 5'h1F, 8'hFF, 8'h00);
        offer(twims_pkg::CMD_PUSH, 5'h00, 8'h00, 8'hFF);
        host(twims_pkg::CMD_START);
        status(twims_pkg::SC_START);
        status(twims_pkg::SC_ADDR_NACK);
        status(twims_pkg::SC_RSTART);
        status(twims_pkg::SC_ADDR_ACK);
        status(twims_pkg::SC_DATA_ACK);
        status(twims_pkg::SC_DATA_NACK);
        status(twims_pkg::SC_ARB_LOST);
        status(twims_pkg::SC_OWN_ADDR);
        host(twims_pkg::CMD_START);  // busy as slave, so ignored
        offer(twims_pkg::CMD_STATUS, twims_pkg::SC_RX_ACKED, 8'hFF, 8'h00);
        offer(twims_pkg::CMD_STATUS, twims_pkg::SC_RX_ACKED, 8'h00, 8'hFF);
        status(twims_pkg::SC_RX_NACKED);
        status(twims_pkg::SC_GEN_CALL);
        status(twims_pkg::SC_SLAVE_STOP);
        offer(twims_pkg::CMD_STATUS, 5'h1F, 8'h00, 8'h00);
        status(5'h00);
        counted += sent - first;
    endtask

    task automatic master_send();
        int n;
        int nacks;
        int first;
        first = sent;
        n     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 6);
        nacks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        repeat (n) host(twims_pkg::CMD_PUSH);
        host(twims_pkg::CMD_START);
        status(twims_pkg::SC_START);
        repeat (nacks) begin
            status(twims_pkg::SC_ADDR_NACK);
            status($urandom_range(0, 1) ? twims_pkg::SC_RSTART : twims_pkg::SC_START);
        end
        if ($urandom_range(0, 15) == 0) begin
            status(twims_pkg::SC_ARB_LOST);
            status(twims_pkg::SC_START);
        end
        status(twims_pkg::SC_ADDR_ACK);
        repeat (n) begin
            if ($urandom_range(0, 19) == 0) noise(1);
            status(($urandom_range(0, 7) == 0) ? twims_pkg::SC_DATA_NACK
                                               : twims_pkg::SC_DATA_ACK);
        end
        // pushes into a full buffer do nothing
        counted += sent - first -
                   ((n > twims_pkg::BUF_DEPTH) ? n - twims_pkg::BUF_DEPTH : 0);
    endtask

    task automatic slave_receive();
        int m;
        int first;
        first = sent;
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
        status($urandom_range(0, 1) ? twims_pkg::SC_OWN_ADDR : twims_pkg::SC_GEN_CALL);
        repeat (m) begin
            if ($urandom_range(0, 24) == 0) noise(1);
            status(twims_pkg::SC_RX_ACKED);
        end
        status($urandom_range(0, 1) ? twims_pkg::SC_RX_NACKED : twims_pkg::SC_SLAVE_STOP);
        if ($urandom_range(0, 1)) host(twims_pkg::CMD_RX_CLEAR);
        counted += sent - first;
    endtask

    task automatic run_traffic(int goal);
        int pick;
        int first;
        while (counted < goal) begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                master_send();
            end else if (pick < 7) begin
                slave_receive();
            end else if (pick == 7) begin
                host(twims_pkg::CMD_RX_CLEAR);
                counted++;
            end else begin
                first = sent;
                noise($urandom_range(1, 4));
                counted += sent - first;
            end
        end
        calm = 1'b0;
    endtask

    // stop offering and wait for every expected result plus the pipeline depth
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        in_valid <= 1'b0;
        in_item  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= twims_pkg::REG_PEER_ADDR;
        cfg_data <= 8'h00;
        i_rst_n  <= 1'b0;
        sent    = 0;
        counted = 0;
        calm    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        run_traffic(ITEMS_PER_SETTING);
        for (int s = 1; s < SETTINGS_RUN; s++) begin
            settle();
            case (s)
                1: begin
                    write_reg(twims_pkg::REG_PEER_ADDR, 8'hFF);
                    write_reg(twims_pkg::REG_RETRY_LIMIT, 8'h00);
                end
                2: begin
                    write_reg(twims_pkg::REG_PEER_ADDR, 8'h00);
                    write_reg(twims_pkg::REG_RETRY_LIMIT, 8'hFF);
                end
                3: begin
                    write_reg(twims_pkg::REG_PEER_ADDR, 8'($urandom));
                    write_reg(twims_pkg::REG_RETRY_LIMIT, 8'($urandom_range(1, 4)));
                end
                default: begin
                    write_reg(twims_pkg::REG_PEER_ADDR, 8'($urandom));
                    write_reg(twims_pkg::REG_RETRY_LIMIT, 8'd5);
                end
            endcase
            run_traffic((s + 1) * ITEMS_PER_SETTING);
        end
        settle();
        repeat (10) @(posedge i_clk);

        $display("%0d transactions under %0d register settings, %0d results compared, %0d bad",
                 sent, SETTINGS_RUN, checked, mismatches);
        $display("covered master sends with address retries and full buffers, slave frames ",
                 "past buffer depth, host commands and stray status codes");
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[twi_master_tx_slave_rx_sequencer.f]
hw/rtl/twims_pkg.sv
hw/rtl/twims_fsm.sv
hw/rtl/twi_master_tx_slave_rx_sequencer.sv
hw/rtl/twims_checker.sv
sim/twims_action_checker.sv
sim/twi_master_tx_slave_rx_sequencer_test.sv
